// File: design/fmsp_pkg.sv
package fmsp_pkg;

   localparam int STORE_DEPTH = 10;

   typedef logic [7:0] char_type;
   typedef logic [3:0] count_type;
   typedef char_type [STORE_DEPTH-1:0] store_type;

   localparam count_type COUNT_SYM_SHORT = 4'd9;
   localparam count_type COUNT_SYM_LONG  = 4'd10;
   localparam count_type COUNT_SAT       = 4'd11;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_OCTAL  = 3'd1,
      ERR_LENGTH = 3'd2,
      ERR_TYPE   = 3'd3,
      ERR_COLUMN = 3'd4,
      ERR_CHAR   = 3'd5
   } err_type;

   localparam logic [15:0] M_IFREG  = 16'o100000;
   localparam logic [15:0] M_IFLNK  = 16'o120000;
   localparam logic [15:0] M_IFSOCK = 16'o140000;
   localparam logic [15:0] M_IFIFO  = 16'o010000;
   localparam logic [15:0] M_IFBLK  = 16'o060000;
   localparam logic [15:0] M_IFCHR  = 16'o020000;
   localparam logic [15:0] M_IFDIR  = 16'o040000;
   localparam logic [15:0] M_ISUID  = 16'o004000;
   localparam logic [15:0] M_ISGID  = 16'o002000;
   localparam logic [15:0] M_ISVTX  = 16'o001000;

   localparam char_type PERM_LETTERS [9] = '{"r", "w", "x", "r", "w", "x", "r", "w", "x"};

   typedef struct packed {
      char_type ch;
      logic     last;
   } item_type;

   typedef struct packed {
      logic [15:0] mode_bits;
      logic [15:0] optional_bits;
      err_type     error;
   } result_type;

endpackage

// File: design/fmsp_symdec.sv
module fmsp_symdec
   import fmsp_pkg::*;
(
   input  store_type   store,
   input  count_type   count,
   input  logic        allow_link,
   output err_type     code,
   output logic [15:0] bits,
   output logic [8:0]  quest
);

   always_comb begin
      char_type    col [9];
      logic [15:0] b;
      logic [8:0]  q;
      err_type     e;
      logic        off;

      b   = '0;
      q   = '0;
      e   = ERR_NONE;
      off = 1'b0;

      if (count == COUNT_SYM_SHORT) begin
         b = M_IFREG;
      end else if (count == COUNT_SYM_LONG) begin
         off = 1'b1;
         case (store[0]) inside
            "l": begin
               if (allow_link) b = M_IFLNK;
               else e = ERR_TYPE;
            end
            "p": b = M_IFIFO;
            "s": b = M_IFSOCK;
            "b": b = M_IFBLK;
            "c": b = M_IFCHR;
            "-", "f": b = M_IFREG;
            "d": b = M_IFDIR;
            default: e = ERR_TYPE;
         endcase
      end else begin
         e = ERR_LENGTH;
      end

      for (int i = 0; i < 9; i++) begin
         col[i] = off ? store[i+1] : store[i];
      end

      if (col[2] == "s" || col[2] == "S") begin
         col[2] = (col[2] == "S") ? 8'("-") : 8'("x");
         b = b | M_ISUID;
      end
      if (col[5] == "l" || col[5] == "L" || col[5] == "s" || col[5] == "S") begin
         col[5] = (col[5] == "s") ? 8'("x") : 8'("-");
         b = b | M_ISGID;
      end
      if (col[8] == "t" || col[8] == "T") begin
         col[8] = (col[8] == "T") ? 8'("-") : 8'("x");
         b = b | M_ISVTX;
      end

      // The leftmost offending column decides the code.
      for (int i = 0; i < 9; i++) begin
         if (e == ERR_NONE) begin
            if (col[i] == PERM_LETTERS[i]) begin
               b[8-i] = 1'b1;
            end else if (col[i] == "-") begin
               b[8-i] = b[8-i];
            end else if (col[i] == "?") begin
               q[8-i] = 1'b1;
            end else if (col[i] inside {"r", "w", "x", "t", "T", "s", "S"}) begin
               e = ERR_COLUMN;
            end else begin
               e = ERR_CHAR;
            end
         end
      end

      code  = e;
      bits  = b;
      quest = q;
   end

endmodule

// File: design/fmsp_parse.sv
module fmsp_parse
   import fmsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  logic       allow_link,
   output result_type result
);

   logic        after_slash_ff, after_slash_in;
   store_type   store_ff, store_in;
   count_type   count_ff, count_in;
   logic        octal_ff, octal_in;
   logic [15:0] octval_ff, octval_in;
   logic [15:0] mode_ff, mode_in;
   logic [15:0] opt_ff, opt_in;
   err_type     err_ff, err_in;

   logic        split;
   logic        digit;
   logic        odigit;
   logic        oct_now;
   logic [15:0] val_fed;
   err_type     err_fed;
   store_type   store_fed;
   count_type   count_fed;
   store_type   dec_store;
   count_type   dec_count;
   err_type     dec_code;
   logic [15:0] dec_bits;
   logic [8:0]  dec_quest;
   err_type     e0;
   logic        o0;
   logic [15:0] v0;
   logic        second;
   err_type     fin_err;
   logic [15:0] fin_mode;
   logic [15:0] fin_opt;
   err_type     final_err;

   fmsp_symdec u_symdec (
      .store      (dec_store),
      .count      (dec_count),
      .allow_link (allow_link),
      .code       (dec_code),
      .bits       (dec_bits),
      .quest      (dec_quest)
   );

   always_comb begin
      split   = (item.ch == "/") && !after_slash_ff;
      digit   = (item.ch >= "0") && (item.ch <= "9");
      odigit  = (item.ch >= "0") && (item.ch <= "7");
      oct_now = octal_ff || ((count_ff == '0) && digit);
      val_fed = (oct_now && odigit) ? ({octval_ff[12:0], 3'b000} + {13'b0, item.ch[2:0]})
                                    : octval_ff;
      err_fed = (oct_now && !odigit && err_ff == ERR_NONE) ? ERR_OCTAL : err_ff;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_fed[i] = (!oct_now && count_ff == 4'(i)) ? item.ch : store_ff[i];
      end
      count_fed = (count_ff < COUNT_SAT) ? count_ff + 4'd1 : count_ff;

      dec_store = split ? store_ff : store_fed;
      dec_count = split ? count_ff : count_fed;

      // A slash closes the first part; otherwise the closing part is the fed one.
      e0     = split ? err_ff : err_fed;
      o0     = split ? octal_ff : oct_now;
      v0     = split ? octval_ff : val_fed;
      second = !split && after_slash_ff;

      fin_err  = e0;
      fin_mode = mode_ff;
      fin_opt  = opt_ff;
      if (e0 == ERR_NONE) begin
         if (o0) begin
            if (second) fin_opt = opt_ff | v0;
            else fin_mode = v0;
         end else if (dec_code != ERR_NONE) begin
            fin_err = dec_code;
         end else if (second) begin
            fin_opt = dec_bits | {7'b0, dec_quest};
         end else begin
            fin_mode = dec_bits;
            fin_opt  = {7'b0, dec_quest};
         end
      end

      // A slash as the final character leaves an empty second part.
      if (split && fin_err == ERR_NONE) final_err = ERR_LENGTH;
      else final_err = fin_err;

      result.error         = final_err;
      result.mode_bits     = (final_err == ERR_NONE) ? fin_mode : '0;
      result.optional_bits = (final_err == ERR_NONE) ? fin_opt : '0;

      store_in = split ? store_ff : store_fed;
      if (item.last) begin
         after_slash_in = 1'b0;
         count_in       = '0;
         octal_in       = 1'b0;
         octval_in      = '0;
         mode_in        = '0;
         opt_in         = '0;
         err_in         = ERR_NONE;
      end else if (split) begin
         after_slash_in = 1'b1;
         count_in       = '0;
         octal_in       = 1'b0;
         octval_in      = '0;
         mode_in        = fin_mode;
         opt_in         = fin_opt;
         err_in         = fin_err;
      end else begin
         after_slash_in = after_slash_ff;
         count_in       = count_fed;
         octal_in       = oct_now;
         octval_in      = val_fed;
         mode_in        = mode_ff;
         opt_in         = opt_ff;
         err_in         = err_fed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_slash_ff <= 1'b0;
         count_ff       <= '0;
         octal_ff       <= 1'b0;
         octval_ff      <= '0;
         mode_ff        <= '0;
         opt_ff         <= '0;
         err_ff         <= ERR_NONE;
      end else if (step) begin
         after_slash_ff <= after_slash_in;
         count_ff       <= count_in;
         octal_ff       <= octal_in;
         octval_ff      <= octval_in;
         mode_ff        <= mode_in;
         opt_ff         <= opt_in;
         err_ff         <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         store_ff <= store_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.last |=> count_ff == '0 && !after_slash_ff && !octal_ff
                            && err_ff == ERR_NONE)
      else $error("Parser state not cleared after the final character.");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_SAT)
      else $error("Character count passed its saturation value.");

   a_first_error_wins: assert property (@(posedge clock) disable iff (reset)
      err_ff != ERR_NONE && !(step && item.last) |=> err_ff == $past(err_ff))
      else $error("A recorded error code was overwritten.");

endmodule

// File: design/file_mode_string_parser.sv
// Parses a file mode string such as 0755, -rwxr-s--x or 0711/044, one character per
// transaction on the req_ channel; the character flagged by req_last closes the string and
// yields one rsp_ transaction with the mandatory mode bits, the optional mode bits and an
// error code (nonzero error returns zero bits). One character is accepted every cycle while
// the input register is not stalled; the parser state update and the ten-character symbolic
// decode are combinational between the input register and the result register, which hold
// a final character and then its result. A final character waits in the input register only
// while the previous result is still held and rsp_ready is low. csr_write_data sets whether
// type letter l is accepted (reset value 1); the user writes it only while no string is in
// progress, as the block itself leaves this unchecked.
module file_mode_string_parser
   import fmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_mode_bits,
   output logic [15:0] rsp_optional_bits,
   output logic [2:0]  rsp_error,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   logic       allow_link_ff;
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       proceed;
   logic       req_take;

   fmsp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (proceed),
      .item       (in_item_ff),
      .allow_link (allow_link_ff),
      .result     (rsp_in)
   );

   always_comb begin
      proceed      = in_valid_ff && (!in_item_ff.last || !rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || proceed;
      req_take     = req_valid && req_ready;
      in_valid_in  = req_take || (in_valid_ff && !proceed);
      rsp_valid_in = (proceed && in_item_ff.last) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_link_ff <= 1'b1;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) allow_link_ff <= csr_write_data;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.ch   <= req_ch;
         in_item_ff.last <= req_last;
      end
      if (proceed && in_item_ff.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode_bits     = rsp_ff.mode_bits;
   assign rsp_optional_bits = rsp_ff.optional_bits;
   assign rsp_error         = rsp_ff.error;

   a_error_zero_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error != ERR_NONE |-> rsp_ff.mode_bits == '0
                                                  && rsp_ff.optional_bits == '0)
      else $error("Error result carries nonzero mode bits.");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proceed |=> in_valid_ff && $stable(in_item_ff))
      else $error("Input register lost a character that was not processed.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      proceed && in_item_ff.last |=> rsp_valid_ff)
      else $error("Final character did not produce a result.");

endmodule

// File: tb/file_mode_string_parser_check.sv
`timescale 1ns / 100ps

module file_mode_string_parser_check
   import fmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_mode_bits,
   input  logic [15:0] rsp_optional_bits,
   input  logic [2:0]  rsp_error,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   output int          fail_count,
   output int          expected_count
);

   logic        link_allowed;
   logic        slash_seen;
   char_type    part_chars [STORE_DEPTH];
   count_type   part_len;
   logic        part_octal;
   logic [15:0] octal_acc;
   logic [15:0] main_mode;
   logic [15:0] main_optional;
   err_type     first_fault;
   result_type  pending_modes [$];
   int          mismatches = 0;

   function automatic void start_part();
      part_len = '0;
      part_octal = 1'b0;
      octal_acc = '0;
   endfunction

   function automatic void clear_parse();
      slash_seen = 1'b0;
      start_part();
      main_mode = '0;
      main_optional = '0;
      first_fault = ERR_NONE;
   endfunction

   function automatic err_type decode_symbolic(output logic [15:0] mode,
                                               output logic [15:0] quest);
      char_type    col [9];
      logic [15:0] b;
      logic [15:0] q;
      logic [15:0] mask;
      int          off;
      b = '0;
      q = '0;
      mask = 16'o400;
      off = 0;
      mode = '0;
      quest = '0;
      if (part_len == COUNT_SYM_SHORT) begin
         b = M_IFREG;
      end else if (part_len == COUNT_SYM_LONG) begin
         off = 1;
         case (part_chars[0])
            "l": begin
               if (!link_allowed) return ERR_TYPE;
               b = M_IFLNK;
            end
            "p": b = M_IFIFO;
            "s": b = M_IFSOCK;
            "b": b = M_IFBLK;
            "c": b = M_IFCHR;
            "-", "f": b = M_IFREG;
            "d": b = M_IFDIR;
            default: return ERR_TYPE;
         endcase
      end else begin
         return ERR_LENGTH;
      end
      for (int i = 0; i < 9; i++) col[i] = part_chars[i + off];
      if (col[2] == "s" || col[2] == "S") begin
         col[2] = (col[2] == "S") ? "-" : "x";
         b |= M_ISUID;
      end
      if (col[5] inside {"l", "L", "s", "S"}) begin
         col[5] = (col[5] == "s") ? "x" : "-";
         b |= M_ISGID;
      end
      if (col[8] == "t" || col[8] == "T") begin
         col[8] = (col[8] == "T") ? "-" : "x";
         b |= M_ISVTX;
      end
      for (int i = 0; i < 9; i++) begin
         if (col[i] == PERM_LETTERS[i]) begin
            b |= mask;
         end else if (col[i] == "?") begin
            q |= mask;
         end else if (col[i] != "-") begin
            if (col[i] inside {"r", "w", "x", "t", "T", "s", "S"}) return ERR_COLUMN;
            return ERR_CHAR;
         end
         mask >>= 1;
      end
      mode = b;
      quest = q;
      return ERR_NONE;
   endfunction

   function automatic void finish_part(input logic second);
      logic [15:0] b;
      logic [15:0] q;
      err_type     e;
      if (first_fault != ERR_NONE) return;
      if (part_octal) begin
         if (second) main_optional |= octal_acc;
         else main_mode = octal_acc;
         return;
      end
      e = decode_symbolic(b, q);
      if (e != ERR_NONE) begin
         first_fault = e;
      end else if (second) begin
         main_optional = b | q;
      end else begin
         main_mode = b;
         main_optional = q;
      end
   endfunction

   function automatic void take_char(input char_type c);
      if (part_len == 0 && c >= "0" && c <= "9") part_octal = 1'b1;
      if (part_octal) begin
         if (c >= "0" && c <= "7") begin
            octal_acc = (octal_acc << 3) | 16'(c - 8'h30);
         end else if (first_fault == ERR_NONE) begin
            first_fault = ERR_OCTAL;
         end
      end else if (part_len < STORE_DEPTH) begin
         part_chars[part_len] = c;
      end
      if (part_len < COUNT_SAT) part_len++;
   endfunction

   function automatic void parse_mode_char(input char_type c, input logic is_last);
      result_type r;
      if (c == "/" && !slash_seen) begin
         finish_part(1'b0);
         slash_seen = 1'b1;
         start_part();
      end else begin
         take_char(c);
      end
      if (is_last) begin
         finish_part(slash_seen);
         r.error = first_fault;
         r.mode_bits = (first_fault == ERR_NONE) ? main_mode : 16'h0000;
         r.optional_bits = (first_fault == ERR_NONE) ? main_optional : 16'h0000;
         pending_modes.push_back(r);
         clear_parse();
      end
   endfunction

   function automatic void check_result();
      result_type want;
      if (pending_modes.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result, mode %o optional %o error %0d", $time,
                  rsp_mode_bits, rsp_optional_bits, rsp_error);
         return;
      end
      want = pending_modes.pop_front();
      if (rsp_mode_bits !== want.mode_bits) begin
         mismatches++;
         $display("%0t: mode_bits expected %o actual %o", $time,
                  want.mode_bits, rsp_mode_bits);
      end
      if (rsp_optional_bits !== want.optional_bits) begin
         mismatches++;
         $display("%0t: optional_bits expected %o actual %o", $time,
                  want.optional_bits, rsp_optional_bits);
      end
      if (rsp_error !== want.error) begin
         mismatches++;
         $display("%0t: error expected %0d actual %0d", $time, want.error, rsp_error);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         link_allowed = 1'b1;
         clear_parse();
         pending_modes.delete();
      end else begin
         if (csr_write_en) link_allowed = csr_write_data;
         if (req_valid && req_ready) parse_mode_char(req_ch, req_last);
         if (rsp_valid && rsp_ready) check_result();
      end
      expected_count <= pending_modes.size();
      fail_count <= mismatches;
   end

endmodule

// File: tb/file_mode_string_parser_tb.sv
`timescale 1ns / 100ps

module file_mode_string_parser_tb
   import fmsp_pkg::*;
();

   localparam int IDLE_LIMIT  = 400;
   localparam int PHASE_CHARS = 340;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [15:0] rsp_mode_bits;
   logic [15:0] rsp_optional_bits;
   logic [2:0]  rsp_error;
   logic        csr_write_en = 1'b0;
   logic        csr_write_data = 1'b1;

   logic        calm_req = 1'b0;
   logic        calm_rsp = 1'b0;
   int          rsp_hold = 0;
   int          rsp_draw;
   int          idle_cycles = 0;
   int          chars_sent = 0;
   int          phase_end;
   int          fail_count;
   int          expected_count;
   char_type    mode_text [$];

   string directed_modes [$] = {
      "0755", "-rwxr-s--x", "-rwx?-x?-x", "0711/044", "lrwsrwsrwt", "drwSr-Sr-T",
      "rw-rw-r--", "brwxrwLr-x", "crwxrwlrwx", "prw-r-sr--", "s?????????",
      "frwxrwxrwx", "177777", "1234567", "089", "9x/abc", "/", "0644/",
      "-rwxrwxrwxr", "qrwxrwxrwx", "-rwxrwxrws", "-rwxrwxrwz", "0700/-rw-r--r--",
      "0755/0/1", "rwxrwxrwx/0777/"
   };

   file_mode_string_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mode_bits     (rsp_mode_bits),
      .rsp_optional_bits (rsp_optional_bits),
      .rsp_error         (rsp_error),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   file_mode_string_parser_check mode_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ch            (req_ch),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mode_bits     (rsp_mode_bits),
      .rsp_optional_bits (rsp_optional_bits),
      .rsp_error         (rsp_error),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .expected_count    (expected_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_draw = calm_rsp ? 0 : $urandom_range(0, 14);
         rsp_hold <= rsp_draw;
         rsp_ready <= (rsp_draw == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_char(input char_type c, input logic is_last);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_last <= is_last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_mode();
      for (int i = 0; i < mode_text.size(); i++) begin
         send_char(mode_text[i], i == mode_text.size() - 1);
      end
   endtask

   function automatic void load_text(input string s);
      mode_text.delete();
      for (int i = 0; i < s.len(); i++) mode_text.push_back(s[i]);
   endfunction

   task automatic send_literal(input string s);
      load_text(s);
      send_mode();
   endtask

   task automatic write_link_allow(input logic value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_count != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic char_type column_char(input int col);
      string specials;
      string letters;
      letters = "rwxtTsS";
      specials = "";
      if (col == 2) specials = "sS";
      else if (col == 5) specials = "lLsS";
      else if (col == 8) specials = "tT";
      if ($urandom_range(0, 79) == 0) return char_type'($urandom_range(0, 255));
      if ($urandom_range(0, 59) == 0) return letters[$urandom_range(0, letters.len() - 1)];
      case ($urandom_range(0, 3))
         0: return "-";
         1: return "?";
         2: if (specials.len() != 0) return specials[$urandom_range(0, specials.len() - 1)];
         default: ;
      endcase
      return PERM_LETTERS[col];
   endfunction

   function automatic void add_symbolic();
      string types;
      types = "-fdbcpsl";
      if ($urandom_range(0, 1) != 0) begin
         if ($urandom_range(0, 11) == 0) begin
            mode_text.push_back(char_type'($urandom_range(0, 255)));
         end else begin
            mode_text.push_back(types[$urandom_range(0, types.len() - 1)]);
         end
      end
      for (int col = 0; col < 9; col++) mode_text.push_back(column_char(col));
      case ($urandom_range(0, 14))
         0: void'(mode_text.pop_back());
         1: mode_text.push_back(column_char($urandom_range(0, 8)));
         default: ;
      endcase
   endfunction

   function automatic void add_octal();
      int n;
      int start;
      int pos;
      start = mode_text.size();
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) mode_text.push_back(char_type'("0" + $urandom_range(0, 7)));
      if ($urandom_range(0, 9) == 0) begin
         pos = start + $urandom_range(0, n - 1);
         mode_text[pos] = $urandom_range(0, 1) ? char_type'("8" + $urandom_range(0, 1))
                                               : char_type'($urandom_range(0, 255));
      end
   endfunction

   function automatic void add_part();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick >= 4) add_symbolic();
      else if (pick >= 1) add_octal();
   endfunction

   task automatic send_random_mode();
      int    kind;
      int    n;
      string noise;
      noise = "/0189-?rwxsltTSL";
      calm_req = ($urandom_range(0, 5) == 0);
      calm_rsp <= ($urandom_range(0, 5) == 0);
      mode_text.delete();
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
         add_symbolic();
      end else if (kind < 9) begin
         add_octal();
      end else if (kind < 16) begin
         add_part();
         mode_text.push_back("/");
         add_part();
         if ($urandom_range(0, 7) == 0) begin
            mode_text.push_back("/");
            add_part();
         end
      end else begin
         n = $urandom_range(1, 14);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               mode_text.push_back(noise[$urandom_range(0, noise.len() - 1)]);
            end else begin
               mode_text.push_back(char_type'($urandom_range(0, 255)));
            end
         end
      end
      if (mode_text.size() == 0) mode_text.push_back("/");
      send_mode();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_modes[i]) send_literal(directed_modes[i]);
      load_text("-rwx-rwxrw");
      mode_text[4] = 8'h00;
      send_mode();
      load_text("07x");
      mode_text[2] = 8'h00;
      send_mode();
      drain_results();

      write_link_allow(1'b0);
      send_literal("lrwxrwxrwx");
      send_literal("0755/lrwxrwxrwx");
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         write_link_allow(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
         phase_end = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_end) send_random_mode();
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
